[hdl/cbig_pkg.sv]
package cbig_pkg;

    // access codes
    localparam logic [1:0] OP_MEM_READ  = 2'd0;
    localparam logic [1:0] OP_MEM_WRITE = 2'd1;
    localparam logic [1:0] OP_IO_READ   = 2'd2;
    localparam logic [1:0] OP_IO_WRITE  = 2'd3;

    // interrupt flag actions
    localparam logic [1:0] IFF_NONE    = 2'd0;
    localparam logic [1:0] IFF_FORCE   = 2'd1;
    localparam logic [1:0] IFF_RESTORE = 2'd2;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 8;
    localparam logic [7:0]  CFG_ROM_BANK_COUNT = 8'd0;
    localparam logic [7:0]  CFG_ROM_WINDOW     = 8'd1;

    // decode constants
    localparam logic [7:0]  PORT_MAPPING  = 8'h28;
    localparam logic [7:0]  PORT_LED      = 8'h29;
    localparam logic [7:0]  OPC_EXX       = 8'hD9;
    localparam logic [7:0]  OPC_EX_AF     = 8'h08;
    localparam logic [7:0]  MAP_SEG_MASK  = 8'h30;
    localparam logic [7:0]  MAP_BANK_MASK = 8'h0F;
    localparam logic [7:0]  UNMAPPED_BYTE = 8'hFF;
    localparam logic [15:0] ROM_BASE      = 16'h4000;
    localparam logic [15:0] CHIP_BASE     = 16'h8000;
    localparam logic [15:0] CHIP_HIGH     = 16'hC000;
    localparam int          CHIP_OFF_W    = 14;
    localparam int          ROM_ADDR_W    = 19;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  rom_data;
        logic        is_m1;
        logic        cpu_iff1;
        logic        cpu_iff2;
    } t_in_word;

    typedef struct packed {
        logic [7:0]            read_data;
        logic                  rom_select;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  chip_read;
        logic                  chip_write;
        logic                  chip_segment;
        logic [CHIP_OFF_W-1:0] chip_offset;
        logic [7:0]            chip_write_data;
        logic [1:0]            iff_action;
        logic                  iff1_out;
        logic                  iff2_out;
    } t_out_word;

    typedef struct packed {
        logic [4:0] rom_bank_count;
        logic       rom_window_large;
    } t_cfg;

    typedef struct packed {
        logic [7:0] mapping_reg;
        logic [7:0] led_reg;
        logic       mapping_on;
        logic       exx_swapped;
        logic       exaf_swapped;
        logic       window_open;
        logic       saved_flag_one;
        logic       saved_flag_two;
    } t_guard_state;

endpackage

[hdl/cbig_cfg_regs.sv]
module cbig_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbig_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    output cbig_pkg::t_cfg                o_cfg
);
    import cbig_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROM_BANK_COUNT: n_cfg.rom_bank_count   = i_cfg_data[4:0];
                CFG_ROM_WINDOW:     n_cfg.rom_window_large = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rom_bank_count: 5'd1, rom_window_large: 1'b1};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hdl/cbig_decode.sv]
module cbig_decode (
    input  cbig_pkg::t_in_word     i_word,
    input  cbig_pkg::t_cfg         i_cfg,
    input  cbig_pkg::t_guard_state i_state,
    output cbig_pkg::t_out_word    o_result,
    output cbig_pkg::t_guard_state o_state
);
    import cbig_pkg::*;

    logic [4:0]  last_bank;
    logic [3:0]  sel_bank;
    logic [3:0]  bank;
    logic [13:0] off14;
    logic        seg;
    logic        was_swapped;
    logic        now_swapped;
    logic        had_window;
    logic        has_window;
    logic [7:0]  port;

    // bank clamp and window placement
    always_comb begin
        last_bank = (i_cfg.rom_bank_count == 5'd0) ? 5'd0 : i_cfg.rom_bank_count - 5'd1;
        sel_bank  = i_state.mapping_reg[3:0] & MAP_BANK_MASK[3:0];
        bank      = ({1'b0, sel_bank} < last_bank) ? sel_bank : last_bank[3:0];
        off14     = i_word.address[CHIP_OFF_W-1:0];
        seg       = (i_word.address >= CHIP_HIGH) ? i_state.mapping_reg[5]
                                                  : i_state.mapping_reg[4];
        port      = i_word.address[7:0];
    end

    // access decode and guard update
    always_comb begin
        o_result           = '0;
        o_result.read_data = UNMAPPED_BYTE;
        o_state            = i_state;
        was_swapped        = i_state.exx_swapped | i_state.exaf_swapped;
        now_swapped        = was_swapped;
        had_window         = i_state.mapping_on && ((i_state.mapping_reg & MAP_SEG_MASK) != 8'd0);
        has_window         = had_window;
        case (i_word.opcode)
            OP_MEM_READ, OP_MEM_WRITE: begin
                if (i_word.address >= CHIP_BASE) begin
                    if (i_word.opcode == OP_MEM_READ) begin
                        o_result.chip_read    = 1'b1;
                        o_result.chip_segment = seg;
                        o_result.chip_offset  = off14;
                    end else if (i_state.mapping_on) begin
                        o_result.chip_write      = 1'b1;
                        o_result.chip_segment    = seg;
                        o_result.chip_offset     = off14;
                        o_result.chip_write_data = i_word.write_data;
                    end
                end else if (i_word.address >= ROM_BASE && i_word.opcode == OP_MEM_READ) begin
                    o_result.read_data  = i_word.rom_data;
                    o_result.rom_select = 1'b1;
                    o_result.rom_address = i_cfg.rom_window_large ? {bank, 1'b0, off14}
                                                                  : {1'b0, bank, off14};
                    // opcode fetch snoop of the register swaps
                    if (i_word.is_m1) begin
                        if (i_word.rom_data == OPC_EXX)
                            o_state.exx_swapped = ~i_state.exx_swapped;
                        if (i_word.rom_data == OPC_EX_AF)
                            o_state.exaf_swapped = ~i_state.exaf_swapped;
                        now_swapped = o_state.exx_swapped | o_state.exaf_swapped;
                        if (now_swapped && !was_swapped) begin
                            o_state.saved_flag_one = i_word.cpu_iff1;
                            o_state.saved_flag_two = i_word.cpu_iff2;
                            o_result.iff_action    = IFF_FORCE;
                        end else if (!now_swapped && was_swapped) begin
                            o_result.iff_action = IFF_RESTORE;
                            o_result.iff1_out   = i_state.saved_flag_one;
                            o_result.iff2_out   = i_state.saved_flag_two;
                        end
                    end
                end
            end
            OP_IO_READ: begin
                if (port == PORT_MAPPING)
                    o_result.read_data = i_state.mapping_reg;
                else if (port == PORT_LED)
                    o_result.read_data = i_state.led_reg;
            end
            OP_IO_WRITE: begin
                if (port == PORT_MAPPING) begin
                    o_state.mapping_on  = 1'b1;
                    o_state.mapping_reg = i_word.write_data;
                    has_window = (i_word.write_data & MAP_SEG_MASK) != 8'd0;
                    // chip window guard
                    if (has_window && !had_window) begin
                        if (!i_state.window_open && !was_swapped) begin
                            o_state.saved_flag_one = i_word.cpu_iff1;
                            o_state.saved_flag_two = i_word.cpu_iff2;
                        end
                        o_state.window_open = 1'b1;
                        o_result.iff_action = IFF_FORCE;
                    end else if (!has_window && had_window) begin
                        o_state.window_open = 1'b0;
                        if (!was_swapped) begin
                            o_result.iff_action = IFF_RESTORE;
                            o_result.iff1_out   = i_state.saved_flag_one;
                            o_result.iff2_out   = i_state.saved_flag_two;
                        end
                    end
                end else if (port == PORT_LED) begin
                    o_state.led_reg = i_word.write_data;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

[hdl/cartridge_bank_and_irq_guard.sv]
// Bus access decoder for a cartridge with banked ROM and a network chip window.
// In channel: one bus access word per handshake (i_in_valid / o_in_stall).
// Out channel: one result word per access (o_out_valid / i_out_stall).
// Config channel: register index and data, always ready; write only while idle.
// An accepted access goes through the input register, then the decode and
// guard update into the result register. Throughput is one access per cycle
// while the receiver does not stall, set by the single decode pass between
// the input register and the result register, which also updates the
// mapping, LED and interrupt guard state for the next access.
// When the receiver stalls, the result word holds; the input register still
// takes one more word and then o_in_stall rises until the result drains.
// Synchronous active-low reset empties both registers, clears mapping, LED,
// swap and window state, sets the saved interrupt flags to one and puts the
// configuration at one ROM bank with the large ROM window.
module cartridge_bank_and_irq_guard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cbig_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cbig_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cbig_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import cbig_pkg::*;

    logic         r_in_valid;
    t_in_word     r_in_word;
    logic         r_out_valid;
    t_out_word    r_out_word;
    t_guard_state r_state;
    t_guard_state n_state;
    t_out_word    n_result;
    t_cfg         cfg;
    logic         out_free;
    logic         in_free;
    logic         advance;

    // flow control
    assign out_free    = !r_out_valid || !i_out_stall;
    assign in_free     = !r_in_valid || out_free;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = !in_free;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    cbig_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cbig_decode u_decode (
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_result (n_result),
        .o_state  (n_state)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= n_result;
        end
    end

    // guard state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mapping_reg:    8'd0,
                         led_reg:        8'd0,
                         mapping_on:     1'b0,
                         exx_swapped:    1'b0,
                         exaf_swapped:   1'b0,
                         window_open:    1'b0,
                         saved_flag_one: 1'b1,
                         saved_flag_two: 1'b1};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

endmodule

[bench/cartridge_bank_and_irq_guard_tb.sv]
`timescale 1ns / 1ps

module cartridge_bank_and_irq_guard_tb;
    import cbig_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PRINT_CAP   = 60;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 155;

    // decode predictor and the queue of result words it has produced
    class decode_scoreboard;
        t_cfg         cfg;
        t_guard_state st;
        t_out_word    pending_decodes[$];
        int           errors;

        function void clear();
            cfg.rom_bank_count   = 5'd1;
            cfg.rom_window_large = 1'b1;
            st                   = '0;
            st.saved_flag_one    = 1'b1;
            st.saved_flag_two    = 1'b1;
            pending_decodes.delete();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_ROM_BANK_COUNT) begin
                cfg.rom_bank_count = data[4:0];
            end else if (idx == CFG_ROM_WINDOW) begin
                cfg.rom_window_large = data[0];
            end
        endfunction

        // bank offset plus the window offset, bank clamped to the last bank
        function logic [ROM_ADDR_W-1:0] rom_location(logic [15:0] addr);
            int unsigned visible;
            int unsigned sel;
            int unsigned last;
            int unsigned bank;
            visible = cfg.rom_window_large ? 32'h8000 : 32'h4000;
            sel     = st.mapping_reg & MAP_BANK_MASK;
            last    = (cfg.rom_bank_count == 0) ? 0 : cfg.rom_bank_count - 1;
            bank    = (sel < last) ? sel : last;
            return ROM_ADDR_W'(bank * visible + ((addr - ROM_BASE) & (visible - 1)));
        endfunction

        // one accepted access: work out its result word and advance the guard state
        function void decode_access(t_in_word w);
            t_out_word  r;
            logic [7:0] port;
            logic       seg;
            logic       was_swapped;
            logic       now_swapped;
            logic       had_window;
            logic       has_window;
            r           = '0;
            r.read_data = UNMAPPED_BYTE;
            port        = w.address[7:0];
            if (w.opcode == OP_MEM_READ || w.opcode == OP_MEM_WRITE) begin
                if (w.address >= CHIP_BASE) begin
                    seg = (w.address >= CHIP_HIGH) ? st.mapping_reg[5] : st.mapping_reg[4];
                    if (w.opcode == OP_MEM_READ) begin
                        r.chip_read    = 1'b1;
                        r.chip_segment = seg;
                        r.chip_offset  = w.address[CHIP_OFF_W-1:0];
                    end else if (st.mapping_on) begin
                        r.chip_write      = 1'b1;
                        r.chip_segment    = seg;
                        r.chip_offset     = w.address[CHIP_OFF_W-1:0];
                        r.chip_write_data = w.write_data;
                    end
                end else if (w.address >= ROM_BASE && w.opcode == OP_MEM_READ) begin
                    r.read_data   = w.rom_data;
                    r.rom_select  = 1'b1;
                    r.rom_address = rom_location(w.address);
                    // swap snoop on opcode fetches
                    if (w.is_m1 && (w.rom_data == OPC_EXX || w.rom_data == OPC_EX_AF)) begin
                        was_swapped = st.exx_swapped || st.exaf_swapped;
                        if (w.rom_data == OPC_EXX) begin
                            st.exx_swapped = !st.exx_swapped;
                        end else begin
                            st.exaf_swapped = !st.exaf_swapped;
                        end
                        now_swapped = st.exx_swapped || st.exaf_swapped;
                        if (now_swapped && !was_swapped) begin
                            st.saved_flag_one = w.cpu_iff1;
                            st.saved_flag_two = w.cpu_iff2;
                            r.iff_action      = IFF_FORCE;
                        end else if (!now_swapped && was_swapped) begin
                            r.iff_action = IFF_RESTORE;
                            r.iff1_out   = st.saved_flag_one;
                            r.iff2_out   = st.saved_flag_two;
                        end
                    end
                end
            end else if (w.opcode == OP_IO_READ) begin
                if (port == PORT_MAPPING) begin
                    r.read_data = st.mapping_reg;
                end else if (port == PORT_LED) begin
                    r.read_data = st.led_reg;
                end
            end else begin
                if (port == PORT_MAPPING) begin
                    had_window     = st.mapping_on && ((st.mapping_reg & MAP_SEG_MASK) != 0);
                    st.mapping_on  = 1'b1;
                    st.mapping_reg = w.write_data;
                    has_window     = (st.mapping_reg & MAP_SEG_MASK) != 0;
                    if (has_window && !had_window) begin
                        if (!st.window_open && !(st.exx_swapped || st.exaf_swapped)) begin
                            st.saved_flag_one = w.cpu_iff1;
                            st.saved_flag_two = w.cpu_iff2;
                        end
                        st.window_open = 1'b1;
                        r.iff_action   = IFF_FORCE;
                    end else if (!has_window && had_window) begin
                        st.window_open = 1'b0;
                        if (!(st.exx_swapped || st.exaf_swapped)) begin
                            r.iff_action = IFF_RESTORE;
                            r.iff1_out   = st.saved_flag_one;
                            r.iff2_out   = st.saved_flag_two;
                        end
                    end
                end else if (port == PORT_LED) begin
                    st.led_reg = w.write_data;
                end
            end
            pending_decodes.push_back(r);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
            end
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (pending_decodes.size() == 0) begin
                report("unexpected word", got.read_data, 0);
                return;
            end
            want = pending_decodes.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.rom_select !== want.rom_select)
                report("rom_select", got.rom_select, want.rom_select);
            if (got.rom_address !== want.rom_address)
                report("rom_address", got.rom_address, want.rom_address);
            if (got.chip_read !== want.chip_read)
                report("chip_read", got.chip_read, want.chip_read);
            if (got.chip_write !== want.chip_write)
                report("chip_write", got.chip_write, want.chip_write);
            if (got.chip_segment !== want.chip_segment)
                report("chip_segment", got.chip_segment, want.chip_segment);
            if (got.chip_offset !== want.chip_offset)
                report("chip_offset", got.chip_offset, want.chip_offset);
            if (got.chip_write_data !== want.chip_write_data)
                report("chip_write_data", got.chip_write_data, want.chip_write_data);
            if (got.iff_action !== want.iff_action)
                report("iff_action", got.iff_action, want.iff_action);
            if (got.iff1_out !== want.iff1_out)
                report("iff1_out", got.iff1_out, want.iff1_out);
            if (got.iff2_out !== want.iff2_out)
                report("iff2_out", got.iff2_out, want.iff2_out);
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 o_cfg_ready;

    decode_scoreboard board = new();
    logic             calm  = 1'b0;
    int               quiet_cycles = 0;
    int               hold_left    = 0;

    cartridge_bank_and_irq_guard dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // idle length: mostly short, now and then long, none in calm stretches
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(12, 30);
    endfunction

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (!calm && $urandom_range(0, 2) == 0) begin
            i_out_stall = 1'b1;
            hold_left   = idle_len();
        end else begin
            i_out_stall = 1'b0;
            hold_left   = $urandom_range(0, 4);
        end
    end

    // result words checked as they leave
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            board.check_result(o_out_word);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("cartridge_bank_and_irq_guard verification failed");
                $finish;
            end
        end
    end

    // present one access word from a falling edge until it is taken
    task send_access(input t_in_word w);
        int gap;
        i_in_word  = w;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.decode_access(w);
        @(negedge i_clk);
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task do_access(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] wdata,
                   input logic [7:0] rdata, input logic m1, input logic f1, input logic f2);
        t_in_word w;
        w.opcode     = op;
        w.address    = addr;
        w.write_data = wdata;
        w.rom_data   = rdata;
        w.is_m1      = m1;
        w.cpu_iff1   = f1;
        w.cpu_iff2   = f2;
        send_access(w);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait for every result to drain, then let the pipeline empty
    task settle();
        i_in_valid = 1'b0;
        while (board.pending_decodes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // random access, mostly well-formed decodes with random content
    function automatic t_in_word random_access();
        t_in_word    w;
        logic [63:0] bits;
        int          kind;
        bits = {$urandom(), $urandom()};
        w    = bits[$bits(t_in_word)-1:0];
        kind = $urandom_range(0, 99);
        if (kind < 32) begin
            w.opcode         = OP_MEM_READ;
            w.address[15:14] = 2'b01;
            if ($urandom_range(0, 3) == 0) begin
                w.rom_data = $urandom_range(0, 1) ? OPC_EXX : OPC_EX_AF;
            end
            w.is_m1 = $urandom_range(0, 9) < 7;
        end else if (kind < 47) begin
            w.opcode      = OP_MEM_READ;
            w.address[15] = 1'b1;
        end else if (kind < 62) begin
            w.opcode      = OP_MEM_WRITE;
            w.address[15] = 1'b1;
        end else if (kind < 72) begin
            w.opcode       = OP_IO_WRITE;
            w.address[7:0] = PORT_MAPPING;
            if ($urandom_range(0, 3) == 0) w.write_data[5:4] = 2'b00;
        end else if (kind < 77) begin
            w.opcode       = OP_IO_WRITE;
            w.address[7:0] = PORT_LED;
        end else if (kind < 85) begin
            w.opcode       = OP_IO_READ;
            w.address[7:0] = $urandom_range(0, 1) ? PORT_MAPPING : PORT_LED;
        end
        return w;
    endfunction

    initial begin
        int bank_counts[PHASES] = '{16, 16, 0, 31, 1, 9};
        int window_bits[PHASES] = '{0, 1, 1, 0, 0, 1};
        board.clear();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: fixed decode cases with four banks and the large window
        write_reg(CFG_ROM_BANK_COUNT, 8'd4);
        write_reg(CFG_ROM_WINDOW, 8'd1);
        do_access(OP_MEM_READ,  16'h0000, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_MEM_WRITE, 16'h3FFF, 8'hAA, 8'h00, 1'b0, 1'b0, 1'b0);
        do_access(OP_MEM_READ,  16'h4000, 8'h00, 8'h55, 1'b1, 1'b1, 1'b1);
        do_access(OP_MEM_READ,  16'h7FFF, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b1);
        do_access(OP_MEM_WRITE, 16'h5000, 8'h12, OPC_EXX, 1'b1, 1'b1, 1'b1);
        do_access(OP_MEM_READ,  16'h8000, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        do_access(OP_MEM_READ,  16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
        do_access(OP_MEM_WRITE, 16'h9000, 8'h77, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_IO_READ,   16'h0028, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_IO_READ,   16'hFF29, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_IO_READ,   16'h1234, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_IO_WRITE,  16'h0029, 8'hA5, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_IO_READ,   16'h0029, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        // open the window with bank 15 clamped, then swap while it is open
        do_access(OP_IO_WRITE,  16'hAB28, 8'h3F, 8'h00, 1'b0, 1'b1, 1'b0);
        do_access(OP_MEM_READ,  16'h6ABC, 8'h00, OPC_EXX, 1'b1, 1'b0, 1'b0);
        do_access(OP_MEM_WRITE, 16'hC123, 8'h5A, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_MEM_WRITE, 16'h8001, 8'hC3, 8'h00, 1'b0, 1'b1, 1'b1);
        // close window while swapped, then undo both swaps
        do_access(OP_IO_WRITE,  16'h0028, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_MEM_READ,  16'h4001, 8'h00, OPC_EX_AF, 1'b1, 1'b1, 1'b1);
        do_access(OP_MEM_READ,  16'h4002, 8'h00, OPC_EXX, 1'b0, 1'b1, 1'b1);
        do_access(OP_IO_READ,   16'h0028, 8'h00, OPC_EXX, 1'b1, 1'b1, 1'b1);
        do_access(OP_MEM_READ,  16'h7000, 8'h00, OPC_EXX, 1'b1, 1'b0, 1'b1);
        do_access(OP_MEM_READ,  16'h7001, 8'h00, OPC_EX_AF, 1'b1, 1'b0, 1'b0);
        // segment bits changing without closing, other port, then close
        do_access(OP_IO_WRITE,  16'h0028, 8'h10, 8'h00, 1'b0, 1'b0, 1'b1);
        do_access(OP_IO_WRITE,  16'h0028, 8'h20, 8'h00, 1'b0, 1'b1, 1'b0);
        do_access(OP_IO_WRITE,  16'h002A, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b1);
        do_access(OP_IO_WRITE,  16'h0028, 8'h0F, 8'h00, 1'b0, 1'b1, 1'b1);

        // random phases over several settings
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(CFG_ROM_BANK_COUNT, bank_counts[p][7:0]);
            write_reg(CFG_ROM_WINDOW, window_bits[p][7:0]);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 59) == 0) calm = !calm;
                send_access(random_access());
            end
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("cartridge_bank_and_irq_guard verification clean");
        end else begin
            $display("cartridge_bank_and_irq_guard verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/cbig_pkg.sv
hdl/cbig_cfg_regs.sv
hdl/cbig_decode.sv
hdl/cartridge_bank_and_irq_guard.sv
bench/cartridge_bank_and_irq_guard_tb.sv
